FILE: hw/rtl/lbr_pkg.sv
// Shared types and constants of the letterbox bilinear resampler.
package lbr_pkg;

   localparam int CHANNELS      = 3;
   localparam int DEF_MAX_SRC_W = 256;
   localparam int DEF_MAX_SRC_H = 256;

   localparam logic [15:0] FILL_Q88 = 16'd32640;
   localparam logic        FUNC_LOAD  = 1'b0;
   localparam logic        FUNC_QUERY = 1'b1;

   // Configuration register indexes
   typedef enum logic [2:0] {
      CSR_SRC_WIDTH  = 3'd0,
      CSR_SRC_HEIGHT = 3'd1,
      CSR_NEW_WIDTH  = 3'd2,
      CSR_NEW_HEIGHT = 3'd3,
      CSR_X_STEP     = 3'd4,
      CSR_Y_STEP     = 3'd5,
      CSR_PAD_LEFT   = 3'd6,
      CSR_PAD_TOP    = 3'd7
   } csr_index_type;

   // Control that travels with the bank read data into the interpolator
   typedef struct packed {
      logic        valid;
      logic        pad;
      logic [15:0] fx;
      logic [15:0] fy;
      logic        ix_odd;
      logic        iy_odd;
      logic        col_same;
      logic        row_same;
   } tap_type;

endpackage

FILE: hw/rtl/letterbox_bilinear_resampler_core.sv
// Top level of the letterbox bilinear resampler: front end, banks, interpolator.
//
//  port group | dir | handshake          | payload
//  req_*      | in  | req_valid/ready    | func, pos_x, pos_y, chan, pixel_in
//  rsp_*      | out | rsp_valid/ready    | sample_value, is_padding
//  csr_*      | in  | csr_we (no wait)   | csr_index, csr_wdata
//
// One transaction per cycle sustained unless rsp_ready stalls; queries pass
// stages A to E. The four neighbor reads come from four banks split by row and
// column parity, each read once per cycle. Loads write in the same stage where
// queries read, so program order is kept without forwarding. Reset clears
// control and registers only; the source store is undefined until loaded.
// Each stage advances when empty or when the next one moves, so bubbles close.
module letterbox_bilinear_resampler_core
   import lbr_pkg::*;
#(
   parameter int MAX_SRC_W = DEF_MAX_SRC_W,
   parameter int MAX_SRC_H = DEF_MAX_SRC_H
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [9:0]  req_pos_x,
   input  logic [9:0]  req_pos_y,
   input  logic [1:0]  req_chan,
   input  logic [7:0]  req_pixel_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_sample_value,
   output logic        rsp_is_padding,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_wdata
);

   localparam int CB    = $clog2(MAX_SRC_W);
   localparam int RB    = $clog2(MAX_SRC_H);
   localparam int HW    = (MAX_SRC_W + 1) / 2;
   localparam int HH    = (MAX_SRC_H + 1) / 2;
   localparam int DEPTH = HH * HW * CHANNELS;
   localparam int AW    = $clog2(DEPTH);

   // Configuration registers
   logic [8:0]  src_width_ff, src_height_ff;
   logic [10:0] new_width_ff, new_height_ff;
   logic [23:0] x_step_ff, y_step_ff;
   logic [9:0]  pad_left_ff, pad_top_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= 9'd256;
         src_height_ff <= 9'd256;
         new_width_ff  <= 11'd256;
         new_height_ff <= 11'd256;
         x_step_ff     <= 24'd65536;
         y_step_ff     <= 24'd65536;
         pad_left_ff   <= 10'd0;
         pad_top_ff    <= 10'd0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_SRC_WIDTH:  src_width_ff  <= csr_wdata[8:0];
            CSR_SRC_HEIGHT: src_height_ff <= csr_wdata[8:0];
            CSR_NEW_WIDTH:  new_width_ff  <= csr_wdata[10:0];
            CSR_NEW_HEIGHT: new_height_ff <= csr_wdata[10:0];
            CSR_X_STEP:     x_step_ff     <= csr_wdata;
            CSR_Y_STEP:     y_step_ff     <= csr_wdata;
            CSR_PAD_LEFT:   pad_left_ff   <= csr_wdata[9:0];
            CSR_PAD_TOP:    pad_top_ff    <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   logic en_a, en_b, en_c;

   // Stage A: window test and window coordinates
   logic        a_valid_ff, a_func_ff, a_pad_ff, a_lastc_ff, a_lastr_ff;
   logic [9:0]  a_c_ff, a_r_ff, a_px_ff, a_py_ff;
   logic [1:0]  a_ch_ff;
   logic [7:0]  a_pix_ff;
   logic [10:0] c_wide, r_wide;
   logic        pad_in;

   assign c_wide = {1'b0, req_pos_x} - {1'b0, pad_left_ff};
   assign r_wide = {1'b0, req_pos_y} - {1'b0, pad_top_ff};
   assign pad_in = c_wide[10] || r_wide[10] ||
                   (c_wide >= new_width_ff) || (r_wide >= new_height_ff);

   assign req_ready = en_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en_a) begin
         a_valid_ff <= req_valid;
      end
      if (en_a) begin
         a_func_ff  <= req_func;
         a_pad_ff   <= pad_in;
         a_lastc_ff <= (c_wide == new_width_ff - 11'd1);
         a_lastr_ff <= (r_wide == new_height_ff - 11'd1);
         a_c_ff     <= c_wide[9:0];
         a_r_ff     <= r_wide[9:0];
         a_px_ff    <= req_pos_x;
         a_py_ff    <= req_pos_y;
         a_ch_ff    <= req_chan;
         a_pix_ff   <= req_pixel_in;
      end
   end

   // Stage B: source positions in Q.16
   logic        b_valid_ff, b_func_ff, b_pad_ff, b_lastc_ff, b_lastr_ff;
   logic [33:0] b_sx_ff, b_sy_ff;
   logic [9:0]  b_px_ff, b_py_ff;
   logic [1:0]  b_ch_ff;
   logic [7:0]  b_pix_ff;

   assign en_a = !a_valid_ff || en_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en_b) begin
         b_valid_ff <= a_valid_ff;
      end
      if (en_b) begin
         b_func_ff  <= a_func_ff;
         b_pad_ff   <= a_pad_ff;
         b_lastc_ff <= a_lastc_ff;
         b_lastr_ff <= a_lastr_ff;
         b_sx_ff    <= {24'b0, a_c_ff} * {10'b0, x_step_ff};
         b_sy_ff    <= {24'b0, a_r_ff} * {10'b0, y_step_ff};
         b_px_ff    <= a_px_ff;
         b_py_ff    <= a_py_ff;
         b_ch_ff    <= a_ch_ff;
         b_pix_ff   <= a_pix_ff;
      end
   end

   assign en_b = !b_valid_ff || en_c;

   // Stage C: neighbor indexes, bank addresses, load writes
   logic [CB-1:0] sw_m1, ix, ix_ev;
   logic [RB-1:0] sh_m1, iy, iy_ev;
   logic [CB:0]   ix_inc;
   logic [RB:0]   iy_inc;
   logic [17:0]   ix_raw, iy_raw;
   logic          colfix, rowfix, load_ok, is_load;
   logic [15:0]   fx, fy;
   logic [1:0]    sch;

   function automatic logic [AW-1:0] bank_addr(input logic [31:0] rh,
                                               input logic [31:0] chh,
                                               input logic [1:0] chn);
      logic [31:0] tmp;
      tmp = (rh * 32'(HW) + chh) * 32'(CHANNELS) + {30'b0, chn};
      return tmp[AW-1:0];
   endfunction

   always_comb begin
      if (src_width_ff == 9'd0) begin
         sw_m1 = '0;
      end else if (32'(src_width_ff) > 32'(MAX_SRC_W)) begin
         sw_m1 = CB'(MAX_SRC_W - 1);
      end else begin
         sw_m1 = CB'(src_width_ff - 9'd1);
      end
      if (src_height_ff == 9'd0) begin
         sh_m1 = '0;
      end else if (32'(src_height_ff) > 32'(MAX_SRC_H)) begin
         sh_m1 = RB'(MAX_SRC_H - 1);
      end else begin
         sh_m1 = RB'(src_height_ff - 9'd1);
      end

      colfix = b_lastc_ff || (sw_m1 == '0);
      rowfix = b_lastr_ff || (sh_m1 == '0);
      ix_raw = b_sx_ff[33:16];
      iy_raw = b_sy_ff[33:16];

      if (colfix || (32'(ix_raw) > 32'(sw_m1))) begin
         ix = sw_m1;
      end else begin
         ix = ix_raw[CB-1:0];
      end
      if (rowfix || (32'(iy_raw) > 32'(sh_m1))) begin
         iy = sh_m1;
      end else begin
         iy = iy_raw[RB-1:0];
      end
      fx = colfix ? 16'd0 : b_sx_ff[15:0];
      fy = rowfix ? 16'd0 : b_sy_ff[15:0];

      // Even-parity neighbor sits at (index + 1) / 2
      ix_inc = {1'b0, ix} + 1'b1;
      iy_inc = {1'b0, iy} + 1'b1;
      ix_ev  = ix_inc[CB:1];
      iy_ev  = iy_inc[RB:1];

      case (b_ch_ff)
         2'd0:    sch = 2'd2;
         2'd1:    sch = 2'd1;
         default: sch = 2'd0;
      endcase

      is_load = b_valid_ff && (b_func_ff == FUNC_LOAD);
      load_ok = (32'(b_px_ff) < 32'(MAX_SRC_W)) && (32'(b_py_ff) < 32'(MAX_SRC_H)) &&
                (32'(b_ch_ff) < 32'(CHANNELS));
   end

   logic [3:0][7:0] rdata;
   tap_type         tap_ff;

   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic [31:0]   rh, chh;
      logic [AW-1:0] raddr, waddr;
      logic          we;

      always_comb begin
         rh    = (b >= 2) ? 32'(iy >> 1) : 32'(iy_ev);
         chh   = (b % 2 == 1) ? 32'(ix >> 1) : 32'(ix_ev);
         raddr = bank_addr(rh, chh, sch);
         waddr = bank_addr({23'b0, b_py_ff[9:1]}, {23'b0, b_px_ff[9:1]}, b_ch_ff);
         we    = en_c && is_load && load_ok && ({b_py_ff[0], b_px_ff[0]} == 2'(b));
      end

      lbr_bank #(.DEPTH(DEPTH), .AW(AW)) u_bank (
         .clock   (clock),
         .wr_en   (we),
         .wr_addr (waddr),
         .wr_data (b_pix_ff),
         .rd_en   (en_c),
         .rd_addr (raddr),
         .rd_data (rdata[b])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ff.valid <= 1'b0;
      end else if (en_c) begin
         tap_ff.valid <= b_valid_ff && (b_func_ff != FUNC_LOAD);
      end
      if (en_c) begin
         tap_ff.pad      <= b_pad_ff;
         tap_ff.fx       <= fx;
         tap_ff.fy       <= fy;
         tap_ff.ix_odd   <= ix[0];
         tap_ff.iy_odd   <= iy[0];
         tap_ff.col_same <= (ix == sw_m1);
         tap_ff.row_same <= (iy == sh_m1);
      end
   end

   lbr_interp u_interp (
      .clock            (clock),
      .reset            (reset),
      .tap              (tap_ff),
      .rdata            (rdata),
      .tap_ready        (en_c),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sample_value (rsp_sample_value),
      .rsp_is_padding   (rsp_is_padding)
   );

endmodule

FILE: hw/rtl/lbr_bank.sv
// One source bank: one write port, one read port with registered read data.
module lbr_bank
   import lbr_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem_ff [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read data holds while the consumer stalls
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/lbr_interp.sv
// Column and row interpolation stages and the result register.
module lbr_interp
   import lbr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  tap_type         tap,
   input  logic [3:0][7:0] rdata,
   output logic            tap_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output logic [15:0]     rsp_sample_value,
   output logic            rsp_is_padding
);

   logic        en_d, en_e, en_o;
   logic        d_valid_ff, d_pad_ff;
   logic [23:0] d_h0_ff, d_h1_ff;
   logic [15:0] d_fy_ff;
   logic        e_valid_ff, e_pad_ff;
   logic [40:0] e_m0_ff, e_m1_ff;
   logic        o_valid_ff, o_pad_ff;
   logic [15:0] o_value_ff;

   logic [16:0] wx0;
   logic [7:0]  p00, p01, p10, p11;
   logic [1:0]  r0, r1;
   logic        c0, c1;
   logic [23:0] h0_in, h1_in;
   logic [40:0] m0_in, m1_in, sum;
   logic [15:0] value_in;

   // Stage enables, collapsing bubbles
   assign en_o      = !o_valid_ff || rsp_ready;
   assign en_e      = !e_valid_ff || en_o;
   assign en_d      = !d_valid_ff || en_e;
   assign tap_ready = !tap.valid || en_d;

   // Pick the four neighbors from the parity banks
   always_comb begin
      c0  = tap.ix_odd;
      c1  = tap.col_same ? tap.ix_odd : !tap.ix_odd;
      r0  = {tap.iy_odd, 1'b0};
      r1  = {(tap.row_same ? tap.iy_odd : !tap.iy_odd), 1'b0};
      p00 = rdata[r0 | {1'b0, c0}];
      p01 = rdata[r0 | {1'b0, c1}];
      p10 = rdata[r1 | {1'b0, c0}];
      p11 = rdata[r1 | {1'b0, c1}];
      wx0 = 17'h10000 - {1'b0, tap.fx};
      h0_in = ({7'b0, wx0} * {16'b0, p00}) + ({16'b0, p01} * {8'b0, tap.fx});
      h1_in = ({7'b0, wx0} * {16'b0, p10}) + ({16'b0, p11} * {8'b0, tap.fx});
   end

   // Column pass register
   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (en_d) begin
         d_valid_ff <= tap.valid;
      end
      if (en_d) begin
         d_pad_ff <= tap.pad;
         d_h0_ff  <= h0_in;
         d_h1_ff  <= h1_in;
         d_fy_ff  <= tap.fy;
      end
   end

   // Row pass products
   assign m0_in = {24'b0, 17'h10000 - {1'b0, d_fy_ff}} * {17'b0, d_h0_ff};
   assign m1_in = {25'b0, d_fy_ff} * {17'b0, d_h1_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (en_e) begin
         e_valid_ff <= d_valid_ff;
      end
      if (en_e) begin
         e_pad_ff <= d_pad_ff;
         e_m0_ff  <= m0_in;
         e_m1_ff  <= m1_in;
      end
   end

   // Sum and round half up to Q8.8
   assign sum      = e_m0_ff + e_m1_ff + 41'h800000;
   assign value_in = e_pad_ff ? FILL_Q88 : sum[39:24];

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (en_o) begin
         o_valid_ff <= e_valid_ff;
      end
      if (en_o) begin
         o_pad_ff   <= e_pad_ff;
         o_value_ff <= value_in;
      end
   end

   assign rsp_valid        = o_valid_ff;
   assign rsp_sample_value = o_value_ff;
   assign rsp_is_padding   = o_pad_ff;

   a_hold_d: assert property (@(posedge clock) disable iff (reset)
      d_valid_ff && !en_e |=> d_valid_ff && $stable(d_h0_ff) && $stable(d_h1_ff))
      else $error("column stage lost data under stall");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_padding |-> rsp_sample_value <= 16'hFF00)
      else $error("interpolated value above full scale");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule
